### rtl/rpn_stack_calculator_assert.svh
// Assertion macros for the RPN stack calculator checker.
// Both sample on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Same-cycle implication.
`define RPN_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int VAL_W           = 32;
    localparam int FRAC_BITS       = 16;

    // Divider: Q16.16 dividend scaled by 2^16, two quotient bits per cycle
    localparam int DIV_DIVIDEND_W = VAL_W + FRAC_BITS;
    localparam int DIV_STEP_BITS  = 2;
    localparam int DIV_ITERS      = DIV_DIVIDEND_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_ITERS + 1);

    typedef enum logic [2:0] {
        MODE_PUSH   = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_SUB    = 3'd2,
        MODE_MUL    = 3'd3,
        MODE_DIV    = 3'd4,
        MODE_FINISH = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_DIVZ    = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_B,
        S_GOT_B,
        S_GOT_A,
        S_CALC,
        S_MUL,
        S_DIV,
        S_PUSH,
        S_EMIT
    } t_state;

endpackage

### rtl/rpn_stack_mem.sv
// ----------------------------------------------------------------------------
// rpn_stack_mem
// Operand stack storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rpn_stack_mem #(
    parameter int DEPTH = rpn_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [rpn_pkg::VAL_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [rpn_pkg::VAL_W-1:0] o_rdata
);
    import rpn_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rpn_pkg::DIV_DIVIDEND_W-1:0] i_dividend,
    input  logic [rpn_pkg::VAL_W-1:0]          i_divisor,
    output logic                               o_done,
    output logic [rpn_pkg::DIV_DIVIDEND_W-1:0] o_quotient
);
    import rpn_pkg::*;

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [DIV_CNT_W-1:0]      r_cnt, n_cnt;
    logic [VAL_W-1:0]          r_rem, n_rem;
    logic [DIV_DIVIDEND_W-1:0] r_quo, n_quo;
    logic [VAL_W-1:0]          r_dvs, n_dvs;

    always_comb begin
        logic [VAL_W:0]            trial;
        logic [VAL_W-1:0]          rem;
        logic [DIV_DIVIDEND_W-1:0] quo;
        rem    = r_rem;
        quo    = r_quo;
        trial  = '0;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_ITERS);
            n_dvs  = i_divisor;
            rem    = '0;
            quo    = i_dividend;
        end else if (r_busy) begin
            for (int k = 0; k < DIV_STEP_BITS; k++) begin
                trial = {rem, quo[DIV_DIVIDEND_W-1]};
                quo   = {quo[DIV_DIVIDEND_W-2:0], 1'b0};
                if (trial >= {1'b0, r_dvs}) begin
                    trial  = trial - {1'b0, r_dvs};
                    quo[0] = 1'b1;
                end
                rem = trial[VAL_W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/rpn_stack_calculator.sv
// Path from the accepting edge to the output register: push and invalid go straight to
// emit; finish and divide by zero pop the top entry first; add, subtract, multiply and
// divide pop two entries, compute and push back. One item at a time; the next transfer is
// taken the cycle after the result is loaded, so divide, with its 24 radix-4 divider steps, is the slowest item.
// Reset (synchronous, active low) empties the stack and drops any held result;
// stack contents are not cleared, only the stack pointer.
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish evaluator over a Q16.16 operand stack held in a synchronous
// memory: pops read the memory, the sequencer computes, a push writes back.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_mode,
    input  logic signed [rpn_pkg::VAL_W-1:0] i_operand_value,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [rpn_pkg::VAL_W-1:0] o_result_value,
    output logic [2:0]                      o_status,
    output logic [7:0]                      o_stack_depth
);
    import rpn_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Clamp a widened sum or shifted product to the signed 32-bit range.
    function automatic logic signed [VAL_W-1:0] sat_sum(input logic signed [VAL_W:0] v);
        if (v[VAL_W] != v[VAL_W-1]) begin
            return v[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_prod(
        input logic signed [DIV_DIVIDEND_W-1:0] v
    );
        if ((v[DIV_DIVIDEND_W-1:VAL_W-1] != '0) && (v[DIV_DIVIDEND_W-1:VAL_W-1] != '1)) begin
            return v[DIV_DIVIDEND_W-1] ? VAL_MIN : VAL_MAX;
        end
        return v[VAL_W-1:0];
    endfunction

    // ---- state ----
    t_state                   r_state, n_state;
    logic [SP_W-1:0]          r_sp, n_sp;
    t_mode                    r_op, n_op;
    t_status                  r_status, n_status;
    logic                     r_under, n_under;
    logic                     r_a_mem, n_a_mem;     // operand a came from memory
    logic                     r_b_mem, n_b_mem;     // operand b came from memory
    logic signed [VAL_W-1:0]  r_a, n_a;
    logic signed [VAL_W-1:0]  r_b, n_b;
    logic signed [VAL_W-1:0]  r_res, n_res;
    logic signed [2*VAL_W-1:0] r_prod, n_prod;
    logic                     r_neg, n_neg;
    // output register
    logic                     r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0]  r_out_res, n_out_res;
    t_status                  r_out_status, n_out_status;
    logic [7:0]               r_out_depth, n_out_depth;

    // ---- memory and divider hook-up ----
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [VAL_W-1:0]         mem_wdata, mem_rdata;
    logic                     div_start, div_done;
    logic [DIV_DIVIDEND_W-1:0] div_quo;
    logic [VAL_W-1:0]         a_mag, b_mag;
    logic signed [VAL_W-1:0]  div_res;
    logic signed [VAL_W-1:0]  rd_val;
    logic [SP_W-1:0]          sp_dec;
    logic                     sp_full, sp_empty;
    logic [SP_W+7:0]          sp_ext;
    logic                     in_xfer, out_free;

    rpn_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({a_mag, {FRAC_BITS{1'b0}}}),
        .i_divisor  (b_mag),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign sp_dec   = r_sp - 1'b1;
    assign sp_full  = (r_sp == SP_W'(STACK_DEPTH));
    assign sp_empty = (r_sp == '0);
    assign sp_ext   = {8'd0, r_sp};
    assign rd_val   = $signed(mem_rdata);

    assign a_mag = r_a[VAL_W-1] ? (~r_a + 1'b1) : r_a;
    assign b_mag = r_b[VAL_W-1] ? (~r_b + 1'b1) : r_b;

    // Apply the quotient sign, clamp the magnitude to the signed range.
    always_comb begin
        if (r_neg) begin
            div_res = (div_quo > DIV_DIVIDEND_W'($unsigned(VAL_MIN))) ? VAL_MIN
                                                            : (VAL_W'(0) - div_quo[VAL_W-1:0]);
        end else begin
            div_res = (div_quo > DIV_DIVIDEND_W'(VAL_MAX)) ? VAL_MAX : div_quo[VAL_W-1:0];
        end
    end

    // Hold the input side off while an item is in flight or during reset.
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // ---- sequencer: next state, memory and divider control ----
    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_op         = r_op;
        n_status     = r_status;
        n_under      = r_under;
        n_a_mem      = r_a_mem;
        n_b_mem      = r_b_mem;
        n_a          = r_a;
        n_b          = r_b;
        n_res        = r_res;
        n_prod       = r_prod;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid;
        n_out_res    = r_out_res;
        n_out_status = r_out_status;
        n_out_depth  = r_out_depth;
        mem_we       = 1'b0;
        mem_waddr    = r_sp[AW-1:0];
        mem_wdata    = r_res;
        mem_re       = 1'b0;
        mem_raddr    = sp_dec[AW-1:0];
        div_start    = 1'b0;

        // Drop the held result once the far side has taken it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op     = t_mode'(i_mode);
                    n_under  = 1'b0;
                    n_res    = '0;
                    n_status = ST_OK;
                    case (t_mode'(i_mode))
                        MODE_PUSH: begin
                            if (sp_full) begin
                                n_status = ST_OVER;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = i_operand_value;
                                n_sp      = r_sp + 1'b1;
                                n_res     = i_operand_value;
                            end
                            n_state = S_EMIT;
                        end
                        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_FINISH: begin
                            n_state = S_POP_B;
                        end
                        default: begin
                            n_status = ST_INVALID;
                            n_state  = S_EMIT;
                        end
                    endcase
                end
            end
            S_POP_B: begin
                // Issue the read of the top entry, or note underflow.
                if (sp_empty) begin
                    n_under = 1'b1;
                    n_b_mem = 1'b0;
                end else begin
                    mem_re  = 1'b1;
                    n_sp    = sp_dec;
                    n_b_mem = 1'b1;
                end
                n_state = S_GOT_B;
            end
            S_GOT_B: begin
                n_b = r_b_mem ? rd_val : '0;
                if (r_op == MODE_FINISH) begin
                    n_res    = r_b_mem ? rd_val : '0;
                    n_status = r_under ? ST_UNDER : ST_OK;
                    n_state  = S_EMIT;
                end else if ((r_op == MODE_DIV) && (!r_b_mem || (rd_val == '0))) begin
                    // Divisor, if any, already popped; leave the dividend in place.
                    n_res    = '0;
                    n_status = ST_DIVZ;
                    n_state  = S_EMIT;
                end else begin
                    if (sp_empty) begin
                        n_under = 1'b1;
                        n_a_mem = 1'b0;
                    end else begin
                        mem_re  = 1'b1;
                        n_sp    = sp_dec;
                        n_a_mem = 1'b1;
                    end
                    n_state = S_GOT_A;
                end
            end
            S_GOT_A: begin
                n_a     = r_a_mem ? rd_val : '0;
                n_state = S_CALC;
            end
            S_CALC: begin
                case (r_op)
                    MODE_ADD: begin
                        n_res   = sat_sum({r_a[VAL_W-1], r_a} + {r_b[VAL_W-1], r_b});
                        n_state = S_PUSH;
                    end
                    MODE_SUB: begin
                        n_res   = sat_sum({r_a[VAL_W-1], r_a} - {r_b[VAL_W-1], r_b});
                        n_state = S_PUSH;
                    end
                    MODE_MUL: begin
                        n_prod  = r_a * r_b;
                        n_state = S_MUL;
                    end
                    MODE_DIV: begin
                        div_start = 1'b1;
                        n_neg     = r_a[VAL_W-1] ^ r_b[VAL_W-1];
                        n_state   = S_DIV;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_MUL: begin
                // Arithmetic shift floors toward minus infinity.
                n_res   = sat_prod(r_prod[2*VAL_W-1:FRAC_BITS]);
                n_state = S_PUSH;
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_res;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // A pop went before or the stack was empty, so the stack always has room here.
                mem_we   = 1'b1;
                n_sp     = r_sp + 1'b1;
                n_status = r_under ? ST_UNDER : ST_OK;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_res    = r_res;
                    n_out_status = r_status;
                    n_out_depth  = sp_ext[7:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_status     <= n_status;
        r_under      <= n_under;
        r_a_mem      <= n_a_mem;
        r_b_mem      <= n_b_mem;
        r_a          <= n_a;
        r_b          <= n_b;
        r_res        <= n_res;
        r_prod       <= n_prod;
        r_neg        <= n_neg;
        r_out_res    <= n_out_res;
        r_out_status <= n_out_status;
        r_out_depth  <= n_out_depth;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_status;
    assign o_stack_depth  = r_out_depth;

endmodule

### rtl/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level assertions for the RPN stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_assert.svh"

module rpn_checker #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [2:0]                       i_mode,
    input logic signed [rpn_pkg::VAL_W-1:0] i_operand_value,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic signed [rpn_pkg::VAL_W-1:0] o_result_value,
    input logic [2:0]                       o_status,
    input logic [7:0]                       o_stack_depth
);
    import rpn_pkg::*;

    localparam logic [7:0] FULL_DEPTH = 8'(STACK_DEPTH);

    // Overflow is only ever reported with the stack full.
    `RPN_ASSERT_IMPLY(a_over_full, o_out_valid && (o_status == ST_OVER), o_stack_depth == FULL_DEPTH, "overflow with stack not full")

    // Failed items carry a zero value.
    `RPN_ASSERT_IMPLY(a_fail_zero, o_out_valid && ((o_status == ST_OVER) || (o_status == ST_DIVZ) || (o_status == ST_INVALID)), o_result_value == '0, "non-zero value on failed item")

    // Underflow means the stack ran dry, so at most the pushed result remains.
    `RPN_ASSERT_IMPLY(a_under_depth, o_out_valid && (o_status == ST_UNDER), o_stack_depth <= 8'd1, "underflow with deep stack")

    // One item at a time: the input side stalls after every transfer.
    `RPN_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall, "second transfer taken while busy")

    // A stalled result holds.
    `RPN_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_value) && $stable(o_status) && $stable(o_stack_depth), "stalled result changed")

endmodule

bind rpn_stack_calculator rpn_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_checker (.*);
